FILE: hdl/ssrb_pkg.sv
// Shared types and constants for the sent segment retransmit buffer.
`default_nettype none
package ssrb_pkg;
   localparam int ENTRIES_PER_TYPE = 16;
   localparam int HANDLE_BITS = 16;
   localparam int SEQ_W = 32;
   localparam int HANDLE_W = 16;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_ACK = 2'd1;
   localparam logic [1:0] REQ_RETX = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_DUP = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_FREED = 3'd3;
   localparam logic [2:0] ST_ACK_DONE = 3'd4;
   localparam logic [2:0] ST_RETX_ENTRY = 3'd5;
   localparam logic [2:0] ST_RETX_DONE = 3'd6;
   localparam logic [2:0] ST_INVALID = 3'd7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ACK = 2'd1,
      OP_RETX = 2'd2,
      OP_INVALID = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic              seg;
      logic [SEQ_W-1:0]  seq_a;
      logic [SEQ_W-1:0]  seq_b;
      logic [HANDLE_W-1:0] handle;
   } cmd_type;
endpackage
`default_nettype wire

FILE: hdl/ssrb_front.sv
// Request decode and command queue feeding the execution engine.
`default_nettype none
module ssrb_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [1:0] req_type,
   input  wire logic [1:0] req_seg_kind,
   input  wire logic [31:0] req_seq_no,
   input  wire logic [15:0] req_handle,
   input  wire logic [31:0] req_ack_seq_control,
   input  wire logic [31:0] req_ack_seq_data,
   input  wire logic [31:0] req_range_start,
   input  wire logic [31:0] req_range_end,
   output ssrb_pkg::cmd_type cmd,
   output logic cmd_valid,
   input  wire logic cmd_take
);
   ssrb_pkg::cmd_type q_ff [2];
   ssrb_pkg::cmd_type c_in;
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic acc;

   assign busy = (cnt_ff == 2'd2);
   assign acc = start && !busy;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ff];

   always_comb begin
      c_in.seg = req_seg_kind[0];
      c_in.handle = req_handle;
      c_in.seq_a = req_seq_no;
      c_in.seq_b = 32'd0;
      if (req_type == ssrb_pkg::REQ_ACK) begin
         c_in.op = ssrb_pkg::OP_ACK;
         c_in.seq_a = req_ack_seq_control;
         c_in.seq_b = req_ack_seq_data;
      end else if (req_type == ssrb_pkg::REQ_UNUSED || req_seg_kind[1]) begin
         c_in.op = ssrb_pkg::OP_INVALID;
      end else if (req_type == ssrb_pkg::REQ_INSERT) begin
         c_in.op = ssrb_pkg::OP_INSERT;
      end else begin
         c_in.op = ssrb_pkg::OP_RETX;
         c_in.seq_a = req_range_start;
         c_in.seq_b = req_range_end;
      end
      cnt_in = cnt_ff + {1'b0, acc} - {1'b0, cmd_take};
      wr_in = wr_ff ^ acc;
      rd_in = rd_ff ^ cmd_take;
   end

   always_ff @(posedge clock) begin
      if (acc) q_ff[wr_ff] <= c_in;
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/ssrb_back.sv
// Execution engine: sorted per-type stores, insert, acknowledge and retransmit scans.
`default_nettype none
module ssrb_back #(
   parameter int ENTRIES_PER_TYPE = ssrb_pkg::ENTRIES_PER_TYPE,
   parameter int HANDLE_BITS = ssrb_pkg::HANDLE_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ssrb_pkg::cmd_type cmd,
   input  wire logic cmd_valid,
   output logic cmd_take,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic rsp_out_type,
   output logic [15:0] rsp_out_handle,
   output logic [31:0] rsp_out_seq,
   output logic [4:0] rsp_freed_control,
   output logic [4:0] rsp_freed_data,
   output logic [4:0] rsp_retransmit_count,
   output logic rsp_range_complete,
   output logic rsp_last
);
   localparam int E = ENTRIES_PER_TYPE;
   localparam int IW = $clog2(E + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   logic [31:0] seq_ff [2][E];
   logic [HANDLE_BITS-1:0] hdl_ff [2][E];
   logic [E-1:0] val_ff [2];
   state_type st_ff, st_in;
   logic t_ff, t_in;
   logic [IW-1:0] i_ff, i_in;
   logic [4:0] fc_ff, fc_in, fd_ff, fd_in;

   logic [2:0] o_st;
   logic o_v, o_t, o_last, o_comp;
   logic [31:0] o_seq;
   logic [15:0] o_h;
   logic [4:0] o_fc, o_fd, o_rc;

   logic [E-1:0] lt, eq;
   logic dup, full;
   logic ins;
   logic [31:0] s_cur;
   logic in_range, ack_hit, ent_ok;
   logic [31:0] want;
   logic [IW-1:0] cur_cnt;
   logic shift_now;

   always_comb begin
      for (int k = 0; k < E; k++) begin
         lt[k] = val_ff[cmd.seg][k] && (seq_ff[cmd.seg][k] < cmd.seq_a);
         eq[k] = val_ff[cmd.seg][k] && (seq_ff[cmd.seg][k] == cmd.seq_a);
      end
      dup = |eq;
      full = val_ff[cmd.seg][E-1];
      ent_ok = (i_ff < IW'(E)) && val_ff[t_ff][i_ff[$clog2(E)>0?$clog2(E)-1:0:0]];
      s_cur = seq_ff[t_ff][i_ff[$clog2(E)>0?$clog2(E)-1:0:0]];
      in_range = (s_cur >= cmd.seq_a) && (s_cur <= cmd.seq_b);
      ack_hit = ent_ok && (s_cur <= (t_ff ? cmd.seq_b : cmd.seq_a));
      want = cmd.seq_b - cmd.seq_a + 32'd1;
      cur_cnt = t_ff ? IW'(fd_ff) : IW'(fc_ff);

      st_in = st_ff; t_in = t_ff; i_in = i_ff; fc_in = fc_ff; fd_in = fd_ff;
      cmd_take = 1'b0; ins = 1'b0; shift_now = 1'b0;
      o_v = 1'b0; o_st = ssrb_pkg::ST_INVALID; o_t = 1'b0; o_last = 1'b0;
      o_seq = 32'd0; o_h = 16'd0; o_fc = 5'd0; o_fd = 5'd0; o_rc = 5'd0; o_comp = 1'b0;

      unique case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  ssrb_pkg::OP_INSERT: begin
                     cmd_take = 1'b1; o_v = 1'b1; o_last = 1'b1; o_t = cmd.seg;
                     if (dup) o_st = ssrb_pkg::ST_DUP;
                     else if (full) o_st = ssrb_pkg::ST_FULL;
                     else begin
                        o_st = ssrb_pkg::ST_INSERTED; ins = 1'b1;
                     end
                  end
                  ssrb_pkg::OP_INVALID: begin
                     cmd_take = 1'b1; o_v = 1'b1; o_last = 1'b1;
                  end
                  ssrb_pkg::OP_ACK: begin
                     st_in = S_SCAN; t_in = 1'b0; i_in = '0; fc_in = '0; fd_in = '0;
                  end
                  default: begin
                     st_in = S_SCAN; t_in = cmd.seg; i_in = '0; fc_in = '0;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (cmd.op == ssrb_pkg::OP_ACK) begin
               if (ack_hit) begin
                  o_v = 1'b1; o_st = ssrb_pkg::ST_FREED; o_t = t_ff;
                  o_seq = s_cur;
                  o_h = 16'(hdl_ff[t_ff][i_ff[$clog2(E)>0?$clog2(E)-1:0:0]]);
                  i_in = i_ff + 1'b1;
                  if (t_ff) fd_in = fd_ff + 5'd1; else fc_in = fc_ff + 5'd1;
               end else begin
                  shift_now = 1'b1;
                  i_in = '0;
                  if (t_ff) st_in = S_DONE; else t_in = 1'b1;
               end
            end else begin
               if (ent_ok) begin
                  i_in = i_ff + 1'b1;
                  if (in_range) begin
                     o_v = 1'b1; o_st = ssrb_pkg::ST_RETX_ENTRY; o_t = t_ff;
                     o_seq = s_cur;
                     o_h = 16'(hdl_ff[t_ff][i_ff[$clog2(E)>0?$clog2(E)-1:0:0]]);
                     fc_in = fc_ff + 5'd1;
                  end
               end else begin
                  st_in = S_IDLE; cmd_take = 1'b1;
                  o_v = 1'b1; o_st = ssrb_pkg::ST_RETX_DONE; o_t = t_ff; o_last = 1'b1;
                  o_rc = fc_ff; o_comp = ({27'd0, fc_ff} == want);
               end
            end
         end
         S_DONE: begin
            st_in = S_IDLE; cmd_take = 1'b1;
            o_v = 1'b1; o_st = ssrb_pkg::ST_ACK_DONE; o_last = 1'b1;
            o_fc = fc_ff; o_fd = fd_ff;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ins) begin
         for (int k = 0; k < E; k++) begin
            if (!lt[k]) begin
               if (k == 0 || lt[k-1 < 0 ? 0 : k-1]) begin
                  seq_ff[cmd.seg][k] <= cmd.seq_a;
                  hdl_ff[cmd.seg][k] <= HANDLE_BITS'(cmd.handle);
               end else begin
                  seq_ff[cmd.seg][k] <= seq_ff[cmd.seg][k-1 < 0 ? 0 : k-1];
                  hdl_ff[cmd.seg][k] <= hdl_ff[cmd.seg][k-1 < 0 ? 0 : k-1];
               end
            end
         end
      end
      if (shift_now) begin
         for (int k = 0; k < E; k++) begin
            if (k + int'(cur_cnt) < E) begin
               seq_ff[t_ff][k] <= seq_ff[t_ff][k + int'(cur_cnt)];
               hdl_ff[t_ff][k] <= hdl_ff[t_ff][k + int'(cur_cnt)];
            end
         end
      end
      rsp_status <= o_st; rsp_out_type <= o_t; rsp_out_handle <= o_h;
      rsp_out_seq <= o_seq; rsp_freed_control <= o_fc; rsp_freed_data <= o_fd;
      rsp_retransmit_count <= o_rc; rsp_range_complete <= o_comp; rsp_last <= o_last;
      if (reset) begin
         st_ff <= S_IDLE; t_ff <= 1'b0; i_ff <= '0; fc_ff <= '0; fd_ff <= '0;
         val_ff[0] <= '0; val_ff[1] <= '0; rsp_valid <= 1'b0;
      end else begin
         st_ff <= st_in; t_ff <= t_in; i_ff <= i_in; fc_ff <= fc_in; fd_ff <= fd_in;
         rsp_valid <= o_v;
         if (ins) val_ff[cmd.seg] <= (val_ff[cmd.seg] << 1) | E'(1);
         if (shift_now) val_ff[t_ff] <= val_ff[t_ff] >> cur_cnt;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/sent_segment_retransmit_buffer_top.sv
// Top level of the sent segment retransmit buffer.
// Insert, invalid: queued, result registered; one item per cycle via 2-deep queue while busy is low.
// Acknowledge: frees acked entries of control, then data store; retransmit: scans each stored entry.
// Scan length is set by the single entry-read port of the back end.
// Results are strobed by rsp_valid and cannot be stalled. Synchronous reset empties both stores.
`default_nettype none
module sent_segment_retransmit_buffer_top #(
   parameter int ENTRIES_PER_TYPE = ssrb_pkg::ENTRIES_PER_TYPE,
   parameter int HANDLE_BITS = ssrb_pkg::HANDLE_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [1:0] req_type,
   input  wire logic [1:0] req_seg_kind,
   input  wire logic [31:0] req_seq_no,
   input  wire logic [15:0] req_handle,
   input  wire logic [31:0] req_ack_seq_control,
   input  wire logic [31:0] req_ack_seq_data,
   input  wire logic [31:0] req_range_start,
   input  wire logic [31:0] req_range_end,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic rsp_out_type,
   output logic [15:0] rsp_out_handle,
   output logic [31:0] rsp_out_seq,
   output logic [4:0] rsp_freed_control,
   output logic [4:0] rsp_freed_data,
   output logic [4:0] rsp_retransmit_count,
   output logic rsp_range_complete,
   output logic rsp_last
);
   ssrb_pkg::cmd_type cmd;
   logic cmd_valid, cmd_take;

   ssrb_front u_front (
      .clock, .reset, .start, .busy, .req_type, .req_seg_kind,
      .req_seq_no, .req_handle, .req_ack_seq_control, .req_ack_seq_data,
      .req_range_start, .req_range_end, .cmd, .cmd_valid, .cmd_take
   );

   ssrb_back #(.ENTRIES_PER_TYPE(ENTRIES_PER_TYPE), .HANDLE_BITS(HANDLE_BITS)) u_back (
      .clock, .reset, .cmd, .cmd_valid, .cmd_take, .rsp_valid, .rsp_status,
      .rsp_out_type, .rsp_out_handle, .rsp_out_seq, .rsp_freed_control,
      .rsp_freed_data, .rsp_retransmit_count, .rsp_range_complete, .rsp_last
   );
endmodule
`default_nettype wire

FILE: tb/sv/tb_sent_segment_retransmit_buffer_top.sv
// Self-checking testbench for the sent segment retransmit buffer top level.
`default_nettype none
module tb_sent_segment_retransmit_buffer_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 2 * ssrb_pkg::ENTRIES_PER_TYPE;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RING = 256;

   typedef struct packed {
      logic [2:0]  status;
      logic        out_type;
      logic [15:0] out_handle;
      logic [31:0] out_seq;
      logic [4:0]  freed_control;
      logic [4:0]  freed_data;
      logic [4:0]  retransmit_count;
      logic        range_complete;
      logic        last;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_type = '0;
   logic [1:0] req_seg_kind = '0;
   logic [31:0] req_seq_no = '0;
   logic [15:0] req_handle = '0;
   logic [31:0] req_ack_seq_control = '0;
   logic [31:0] req_ack_seq_data = '0;
   logic [31:0] req_range_start = '0;
   logic [31:0] req_range_end = '0;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic rsp_out_type;
   logic [15:0] rsp_out_handle;
   logic [31:0] rsp_out_seq;
   logic [4:0] rsp_freed_control;
   logic [4:0] rsp_freed_data;
   logic [4:0] rsp_retransmit_count;
   logic rsp_range_complete;
   logic rsp_last;

   // Model of the stores
   logic [31:0] mdl_seq [DEPTH];
   logic [15:0] mdl_handle [DEPTH];
   int          mdl_count [2];

   outcome_type exp_ring [RING];
   int exp_wr = 0;
   int exp_rd = 0;
   int errors = 0;
   int cycles = 0;
   int transfers = 0;
   int results_seen = 0;
   bit no_idle = 1'b0;

   sent_segment_retransmit_buffer_top DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("sent_segment_retransmit_buffer_top regression: fail");
         $finish;
      end
   end

   function automatic outcome_type mk(logic [2:0] st, logic ty, logic [15:0] h,
                                      logic [31:0] s, logic [4:0] fc, logic [4:0] fd,
                                      logic [4:0] rc, logic rcomp, logic lst);
      outcome_type o;
      o.status = st; o.out_type = ty; o.out_handle = h; o.out_seq = s;
      o.freed_control = fc; o.freed_data = fd; o.retransmit_count = rc;
      o.range_complete = rcomp; o.last = lst;
      return o;
   endfunction

   function automatic void queue_result(outcome_type o);
      exp_ring[exp_wr % RING] = o;
      exp_wr++;
   endfunction

   function automatic int release_acked(int t, logic [31:0] ack);
      int b, m;
      b = t * ssrb_pkg::ENTRIES_PER_TYPE;
      m = 0;
      while (m < mdl_count[t] && mdl_seq[b+m] <= ack) begin
         queue_result(mk(ssrb_pkg::ST_FREED, t[0], mdl_handle[b+m], mdl_seq[b+m],
                         0, 0, 0, 0, 0));
         m++;
      end
      for (int i = 0; i + m < mdl_count[t]; i++) begin
         mdl_seq[b+i] = mdl_seq[b+i+m];
         mdl_handle[b+i] = mdl_handle[b+i+m];
      end
      mdl_count[t] -= m;
      return m;
   endfunction

   task automatic predict_buffer(logic [1:0] rt, logic [1:0] st, logic [31:0] sq,
                                 logic [15:0] h, logic [31:0] ac, logic [31:0] ad,
                                 logic [31:0] lo, logic [31:0] hi);
      int t, b, p, fc, fd, cnt;
      logic [31:0] want;
      t = st;
      b = t * ssrb_pkg::ENTRIES_PER_TYPE;
      if (rt == ssrb_pkg::REQ_ACK) begin
         fc = release_acked(0, ac);
         fd = release_acked(1, ad);
         queue_result(mk(ssrb_pkg::ST_ACK_DONE, 0, 0, 0, 5'(fc), 5'(fd), 0, 0, 1));
      end else if (rt == ssrb_pkg::REQ_UNUSED || st > 2'd1) begin
         queue_result(mk(ssrb_pkg::ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 1));
      end else if (rt == ssrb_pkg::REQ_INSERT) begin
         p = 0;
         while (p < mdl_count[t] && mdl_seq[b+p] < sq) p++;
         if (p < mdl_count[t] && mdl_seq[b+p] == sq)
            queue_result(mk(ssrb_pkg::ST_DUP, st[0], 0, 0, 0, 0, 0, 0, 1));
         else if (mdl_count[t] >= ssrb_pkg::ENTRIES_PER_TYPE)
            queue_result(mk(ssrb_pkg::ST_FULL, st[0], 0, 0, 0, 0, 0, 0, 1));
         else begin
            for (int i = mdl_count[t]; i > p; i--) begin
               mdl_seq[b+i] = mdl_seq[b+i-1];
               mdl_handle[b+i] = mdl_handle[b+i-1];
            end
            mdl_seq[b+p] = sq;
            mdl_handle[b+p] = h;
            mdl_count[t]++;
            queue_result(mk(ssrb_pkg::ST_INSERTED, st[0], 0, 0, 0, 0, 0, 0, 1));
         end
      end else begin
         cnt = 0;
         want = hi - lo + 32'd1;
         for (int i = 0; i < mdl_count[t]; i++)
            if (mdl_seq[b+i] >= lo && mdl_seq[b+i] <= hi) begin
               queue_result(mk(ssrb_pkg::ST_RETX_ENTRY, st[0], mdl_handle[b+i],
                               mdl_seq[b+i], 0, 0, 0, 0, 0));
               cnt++;
            end
         queue_result(mk(ssrb_pkg::ST_RETX_DONE, st[0], 0, 0, 0, 0, 5'(cnt),
                         32'(cnt) == want, 1));
      end
   endtask

   // Check each result transfer against the oldest expectation
   always @(posedge clock) begin
      outcome_type got, exp;
      if (!reset && rsp_valid) begin
         got = mk(rsp_status, rsp_out_type, rsp_out_handle, rsp_out_seq, rsp_freed_control,
                  rsp_freed_data, rsp_retransmit_count, rsp_range_complete, rsp_last);
         results_seen++;
         if (exp_wr == exp_rd) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            exp = exp_ring[exp_rd % RING];
            exp_rd++;
            if (got.status != exp.status)
               $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
            if (got.out_type != exp.out_type)
               $display("%0t: out_type exp %0d got %0d", $time, exp.out_type, got.out_type);
            if (got.out_handle != exp.out_handle)
               $display("%0t: out_handle exp %h got %h", $time, exp.out_handle,
                        got.out_handle);
            if (got.out_seq != exp.out_seq)
               $display("%0t: out_seq exp %h got %h", $time, exp.out_seq, got.out_seq);
            if (got.freed_control != exp.freed_control)
               $display("%0t: freed_control exp %0d got %0d", $time, exp.freed_control,
                        got.freed_control);
            if (got.freed_data != exp.freed_data)
               $display("%0t: freed_data exp %0d got %0d", $time, exp.freed_data,
                        got.freed_data);
            if (got.retransmit_count != exp.retransmit_count)
               $display("%0t: retransmit_count exp %0d got %0d", $time,
                        exp.retransmit_count, got.retransmit_count);
            if (got.range_complete != exp.range_complete)
               $display("%0t: range_complete exp %0d got %0d", $time, exp.range_complete,
                        got.range_complete);
            if (got.last != exp.last)
               $display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
            if (got != exp) errors++;
         end
      end
   end

   task automatic send_request(logic [1:0] rt, logic [1:0] st, logic [31:0] sq,
                               logic [15:0] h, logic [31:0] ac, logic [31:0] ad,
                               logic [31:0] lo, logic [31:0] hi);
      while (!no_idle && $urandom_range(99) < 27) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= rt; req_seg_kind <= st; req_seq_no <= sq; req_handle <= h;
      req_ack_seq_control <= ac; req_ack_seq_data <= ad;
      req_range_start <= lo; req_range_end <= hi;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_buffer(rt, st, sq, h, ac, ad, lo, hi);
      transfers++;
   endtask

   task automatic test_directed;
      send_request(ssrb_pkg::REQ_INSERT, 0, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0, 0);
      send_request(ssrb_pkg::REQ_INSERT, 0, 32'h0, 16'h0, 0, 0, 0, 0);
      send_request(ssrb_pkg::REQ_INSERT, 0, 32'h0, 16'h1234, 0, 0, 0, 0);
      send_request(ssrb_pkg::REQ_INSERT, 1, 32'h8000_0000, 16'hA5A5, 0, 0, 0, 0);
      send_request(ssrb_pkg::REQ_INSERT, 2, 32'h5, 16'h5, 0, 0, 0, 0);
      send_request(ssrb_pkg::REQ_INSERT, 3, 32'h6, 16'h6, 0, 0, 0, 0);
      send_request(ssrb_pkg::REQ_UNUSED, 0, 32'h7, 16'h7, 0, 0, 0, 0);
      send_request(ssrb_pkg::REQ_RETX, 0, 0, 0, 0, 0, 32'h0, 32'hFFFF_FFFF);
      send_request(ssrb_pkg::REQ_RETX, 1, 0, 0, 0, 0, 32'h9, 32'h2);
      send_request(ssrb_pkg::REQ_RETX, 3, 0, 0, 0, 0, 0, 5);
      send_request(ssrb_pkg::REQ_ACK, 3, 0, 0, 32'hFFFF_FFFF, 32'h0, 0, 0);
      for (int i = 0; i < ssrb_pkg::ENTRIES_PER_TYPE; i++)
         send_request(ssrb_pkg::REQ_INSERT, 1, 32'(i * 3), 16'(i), 0, 0, 0, 0);
      send_request(ssrb_pkg::REQ_INSERT, 1, 32'd3, 16'h1, 0, 0, 0, 0);
      send_request(ssrb_pkg::REQ_INSERT, 1, 32'd4, 16'h1, 0, 0, 0, 0);
      send_request(ssrb_pkg::REQ_RETX, 1, 0, 0, 0, 0, 32'd0, 32'd45);
      send_request(ssrb_pkg::REQ_ACK, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
   endtask

   task automatic test_random;
      logic [31:0] b, lo;
      b = $urandom;
      for (int i = 0; i < 90; i++) begin
         no_idle = (i >= 30 && i < 60);
         lo = b + $urandom_range(40);
         case ($urandom_range(9))
            0, 1, 2, 3, 4:
               send_request(ssrb_pkg::REQ_INSERT, ($urandom_range(19) == 0) ? 2'($urandom) :
                            2'($urandom_range(1)),
                            ($urandom_range(9) == 0) ? $urandom : b + $urandom_range(60),
                            16'($urandom), $urandom, $urandom, $urandom, $urandom);
            5, 6:
               send_request(ssrb_pkg::REQ_ACK, 2'($urandom), $urandom,
                            16'($urandom), b + $urandom_range(50), b + $urandom_range(50),
                            $urandom, $urandom);
            7, 8:
               send_request(ssrb_pkg::REQ_RETX, 2'($urandom_range(1)), $urandom,
                            16'($urandom), $urandom, $urandom, lo,
                            ($urandom_range(4) == 0) ? $urandom : lo + $urandom_range(30));
            default:
               send_request(2'($urandom), 2'($urandom), $urandom, 16'($urandom),
                            $urandom, $urandom, $urandom, $urandom);
         endcase
         if ($urandom_range(39) == 0) b = $urandom;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      mdl_count[0] = 0;
      mdl_count[1] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      start <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Covered %0d request transfers and %0d result transfers:", transfers,
               results_seen);
      $display("inserts, duplicates, full stores, acknowledges, retransmits, bad codes.");
      if (errors == 0 && exp_wr == exp_rd)
         $display("sent_segment_retransmit_buffer_top regression: pass");
      else
         $display("sent_segment_retransmit_buffer_top regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
hdl/ssrb_pkg.sv
hdl/ssrb_front.sv
hdl/ssrb_back.sv
hdl/sent_segment_retransmit_buffer_top.sv
tb/sv/tb_sent_segment_retransmit_buffer_top.sv
